// ----- hdl/dmac_pkg.sv -----
// Shared types and constants for the double-precision multiply-accumulate block.
// Holds channel beat structs, op codes, FMA request/response structs.
// No dependencies.
package dmac_pkg;

    localparam int DEFAULT_MAX_ORDER = 64;

    localparam logic [2:0] OP_WRITE_A = 3'd0;
    localparam logic [2:0] OP_WRITE_B = 3'd1;
    localparam logic [2:0] OP_WRITE_C = 3'd2;
    localparam logic [2:0] OP_RUN     = 3'd3;
    localparam logic [2:0] OP_READ_C  = 3'd4;

    localparam logic [6:0]  ORDER_RESET = 7'd64;
    localparam logic [63:0] FP_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] FP_INF      = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [63:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic        run_done;
    } out_beat_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } fma_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fma_rsp_t;

endpackage

// ----- hdl/dgemm_multiply_accumulate.sv -----
// Top level: binary64 matrix multiply-accumulate C = C + A*B, column-major.
// Holds the A, B, C memories and the run sequencer; uses dmac_fma.
// Depends on dmac_pkg and dmac_fma.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one beat per command:
//   write A, write B, write C at (row, col), start a run, or read C(row, col).
//   out channel (out_valid/out_ready/out_data) returns one beat per run
//   (run_done = 1, read_value = 0) and one per read (run_done = 0).
//   cfg_write_en/cfg_write_data set the matrix order n; write only when idle.
// Flow:
//   element write: one beat per cycle while in_ready is high.
//   read of C: the memory read is registered, and out_valid rises after the
//   T_RDOUT state; the block takes no new beat while in T_RDOUT.
//   run: the block waits on the FMA for each product term; the FMA time is set
//   by the iterative FMA unit: multiplier passes plus 1/16-bit shift steps.
//   The block takes no beat while a run is busy.
// Reset: control clears at once, order returns to 64. The memories are not
//   cleared; an element must be written before it is read or used in a run.
// Stall: a finished result sits in the output register until taken; in_ready
//   stays low while it waits and is not being taken.
module dgemm_multiply_accumulate #(
    parameter int MAX_ORDER = dmac_pkg::DEFAULT_MAX_ORDER
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dmac_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dmac_pkg::out_beat_t out_data,
    input  logic               cfg_write_en,
    input  logic [6:0]         cfg_write_data
);
    import dmac_pkg::*;

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW    = $clog2(MAX_ORDER + 1);

    typedef enum logic [7:0] {
        T_IDLE   = 8'b00000001,
        T_RDOUT  = 8'b00000010,
        T_CLOAD  = 8'b00000100,
        T_CGET   = 8'b00001000,
        T_FSTART = 8'b00010000,
        T_FWAIT  = 8'b00100000,
        T_FADDR  = 8'b01000000,
        T_CWRITE = 8'b10000000
    } tstate_t;

    tstate_t   state_reg, state_next;
    logic [6:0] order_reg;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [NW-1:0] n_last_reg, n_last_next, n_eff;
    logic [63:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_data_reg, out_data_next;

    logic [63:0] mem_a [DEPTH];
    logic [63:0] mem_b [DEPTH];
    logic [63:0] mem_c [DEPTH];
    logic [63:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic        a_we, b_we, c_we;
    logic [63:0] c_wdata;
    logic [AW-1:0] in_addr, a_raddr, b_raddr, c_run_addr, c_addr;

    logic in_accept, in_inside, i_last, j_last, k_last;
    fma_req_t fma_req;
    fma_rsp_t fma_rsp;

    assign in_accept = in_valid && in_ready;
    assign in_inside = (32'(in_data.row) < 32'(MAX_ORDER)) &&
                       (32'(in_data.col) < 32'(MAX_ORDER));
    assign in_addr   = AW'(32'(in_data.row) + 32'(in_data.col) * 32'(MAX_ORDER));
    assign a_raddr   = AW'(32'(i_reg) + 32'(k_reg) * 32'(MAX_ORDER));
    assign b_raddr   = AW'(32'(k_reg) + 32'(j_reg) * 32'(MAX_ORDER));
    assign c_run_addr = AW'(32'(i_reg) + 32'(j_reg) * 32'(MAX_ORDER));
    assign c_addr    = (state_reg == T_IDLE) ? in_addr : c_run_addr;

    // order above the memory size saturates
    assign n_eff  = (32'(order_reg) > 32'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(order_reg);
    assign i_last = NW'(i_reg) == n_last_reg;
    assign j_last = NW'(j_reg) == n_last_reg;
    assign k_last = NW'(k_reg) == n_last_reg;

    assign in_ready = (state_reg == T_IDLE) && (!out_valid_reg || out_ready);

    assign fma_req.start = (state_reg == T_FSTART);
    assign fma_req.a     = a_rd_reg;
    assign fma_req.b     = b_rd_reg;
    assign fma_req.c     = acc_reg;

    dmac_fma u_fma (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fma_req),
        .rsp   (fma_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        n_last_next    = n_last_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        c_wdata        = in_data.value;
        case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_data.op)
                        OP_WRITE_A: a_we = in_inside;
                        OP_WRITE_B: b_we = in_inside;
                        OP_WRITE_C: c_we = in_inside;
                        OP_RUN:
                        begin
                            if (n_eff == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{read_value: 64'd0, run_done: 1'b1};
                            end
                            else
                            begin
                                n_last_next = n_eff - NW'(1);
                                i_next      = '0;
                                j_next      = '0;
                                k_next      = '0;
                                state_next  = T_CLOAD;
                            end
                        end
                        OP_READ_C:
                        begin
                            if (in_inside)
                                state_next = T_RDOUT;
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{read_value: 64'd0, run_done: 1'b0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            T_RDOUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{read_value: c_rd_reg, run_done: 1'b0};
                state_next     = T_IDLE;
            end
            T_CLOAD:
            begin
                state_next = T_CGET;
            end
            T_CGET:
            begin
                acc_next   = c_rd_reg;
                state_next = T_FSTART;
            end
            T_FSTART:
            begin
                state_next = T_FWAIT;
            end
            T_FWAIT:
            begin
                if (fma_rsp.done)
                begin
                    acc_next = fma_rsp.result;
                    if (k_last)
                        state_next = T_CWRITE;
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = T_FADDR;
                    end
                end
            end
            T_FADDR:
            begin
                // read registers pick up the new k this cycle
                state_next = T_FSTART;
            end
            T_CWRITE:
            begin
                c_we    = 1'b1;
                c_wdata = acc_reg;
                k_next  = '0;
                state_next = T_CLOAD;
                if (i_last)
                begin
                    i_next = '0;
                    if (j_last)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{read_value: 64'd0, run_done: 1'b1};
                        state_next     = T_IDLE;
                    end
                    else
                        j_next = j_reg + IW'(1);
                end
                else
                    i_next = i_reg + IW'(1);
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            order_reg     <= ORDER_RESET;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_last_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            n_last_reg    <= n_last_next;
            if (cfg_write_en)
                order_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // memories: one write and one registered read each per cycle
    always_ff @(posedge clk)
    begin
        if (a_we)
            mem_a[in_addr] <= in_data.value;
        a_rd_reg <= mem_a[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            mem_b[in_addr] <= in_data.value;
        b_rd_reg <= mem_b[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            mem_c[c_addr] <= c_wdata;
        c_rd_reg <= mem_c[c_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fma_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fma_rsp.done |-> state_reg == T_FWAIT)
        else $error("FMA result outside wait state");

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_FSTART || state_reg == T_CWRITE) |->
            (NW'(i_reg) <= n_last_reg && NW'(j_reg) <= n_last_reg &&
             NW'(k_reg) <= n_last_reg))
        else $error("run counter beyond order");

    a_run_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CWRITE && i_last && j_last) |=>
            (out_valid_reg && out_data_reg.run_done && state_reg == T_IDLE))
        else $error("run end without done beat");

    a_empty_run_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.op == OP_RUN && n_eff == '0) |=>
            (out_valid_reg && out_data_reg.run_done))
        else $error("empty run without done beat");

endmodule

// ----- hdl/dmac_fma.sv -----
// Iterative binary64 fused multiply-add, result = a*b + c, one rounding.
// One 32x32 multiplier over four passes, shared 1/16-bit shifter steps.
// Depends on dmac_pkg.
module dmac_fma (
    input  logic              clk,
    input  logic              rst_n,
    input  dmac_pkg::fma_req_t req,
    output dmac_pkg::fma_rsp_t rsp
);
    import dmac_pkg::*;

    typedef enum logic [10:0] {
        F_IDLE   = 11'b00000000001,
        F_MUL    = 11'b00000000010,
        F_NORMP  = 11'b00000000100,
        F_NORMQ  = 11'b00000001000,
        F_CMP    = 11'b00000010000,
        F_ALIGN  = 11'b00000100000,
        F_ADD    = 11'b00001000000,
        F_NORMR  = 11'b00010000000,
        F_RSET   = 11'b00100000000,
        F_RSHIFT = 11'b01000000000,
        F_ROUND  = 11'b10000000000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [127:0]       x_reg, x_next, y_reg, y_next;
    logic signed [15:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [15:0]        d_reg, d_next;
    logic               sticky_reg, sticky_next;
    logic               sp_reg, sp_next, sc_reg, sc_next, cz_reg, cz_next;
    logic               sign_reg, sign_next;
    logic [10:0]        base_reg, base_next;
    logic [63:0]        pp_reg, pp_next;
    logic [63:0]        res_reg, res_next;
    logic               done_reg, done_next;

    // operand decode
    logic [10:0] ea, eb, ec, ea_eff, eb_eff, ec_eff;
    logic [51:0] fa, fb, fc;
    logic        az, bz, cz, sp, sc;
    logic        special;
    logic [63:0] special_res;

    // multiplier
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mul_p;
    logic [6:0]   pshift;
    logic [127:0] x_add;

    // shared right shifter with sticky
    logic [127:0] rs_y;
    logic [15:0]  rs_d;
    logic         rs_st;

    logic signed [15:0] exb;
    logic [127:0]       ys;
    logic [63:0]        mant, mant_r, enc;
    logic               rbit;

    assign ea = req.a[62:52];
    assign eb = req.b[62:52];
    assign ec = req.c[62:52];
    assign fa = req.a[51:0];
    assign fb = req.b[51:0];
    assign fc = req.c[51:0];
    assign az = (ea == 11'd0) && (fa == 52'd0);
    assign bz = (eb == 11'd0) && (fb == 52'd0);
    assign cz = (ec == 11'd0) && (fc == 52'd0);
    assign sp = req.a[63] ^ req.b[63];
    assign sc = req.c[63];
    assign ea_eff = (ea == 11'd0) ? 11'd1 : ea;
    assign eb_eff = (eb == 11'd0) ? 11'd1 : eb;
    assign ec_eff = (ec == 11'd0) ? 11'd1 : ec;

    always_comb
    begin
        special     = 1'b1;
        special_res = req.c;
        if ((ea == 11'h7FF && fa != 52'd0) || (eb == 11'h7FF && fb != 52'd0) ||
            (ec == 11'h7FF && fc != 52'd0))
        begin
            special_res = FP_QNAN;
        end
        else if (ea == 11'h7FF || eb == 11'h7FF)
        begin
            if (az || bz || (ec == 11'h7FF && sc != sp))
                special_res = FP_QNAN;
            else
                special_res = {sp, FP_INF[62:0]};
        end
        else if (ec == 11'h7FF)
        begin
            special_res = req.c;
        end
        else if (az || bz)
        begin
            if (cz)
                special_res = (sp == sc) ? {sp, 63'd0} : 64'd0;
            else
                special_res = req.c;
        end
        else
        begin
            special = 1'b0;
        end
    end

    // partial products: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_x = ma_reg[31:0];          mul_y = mb_reg[31:0]; end
            3'd1:    begin mul_x = ma_reg[31:0];          mul_y = {11'd0, mb_reg[52:32]}; end
            3'd2:    begin mul_x = {11'd0, ma_reg[52:32]}; mul_y = mb_reg[31:0]; end
            default: begin mul_x = {11'd0, ma_reg[52:32]}; mul_y = {11'd0, mb_reg[52:32]}; end
        endcase
        case (step_reg)
            3'd1:    pshift = 7'd0;
            3'd2:    pshift = 7'd32;
            3'd3:    pshift = 7'd32;
            default: pshift = 7'd64;
        endcase
    end

    assign mul_p = 64'(mul_x) * 64'(mul_y);
    assign x_add = {64'd0, pp_reg} << pshift;

    always_comb
    begin
        rs_y  = y_reg;
        rs_d  = d_reg;
        rs_st = sticky_reg;
        if (d_reg >= 16'd128)
        begin
            rs_y  = '0;
            rs_d  = 16'd0;
            rs_st = sticky_reg | (y_reg != 128'd0);
        end
        else if (d_reg >= 16'd16)
        begin
            rs_y  = y_reg >> 16;
            rs_d  = d_reg - 16'd16;
            rs_st = sticky_reg | (y_reg[15:0] != 16'd0);
        end
        else if (d_reg != 16'd0)
        begin
            rs_y  = y_reg >> 1;
            rs_d  = d_reg - 16'd1;
            rs_st = sticky_reg | y_reg[0];
        end
    end

    assign exb    = ex_reg + 16'sd1149;
    assign ys     = {y_reg[127:1], y_reg[0] | sticky_reg};
    assign rbit   = y_reg[0];
    assign mant   = y_reg[64:1];
    assign mant_r = mant + 64'(rbit & (sticky_reg | mant[0]));
    assign enc    = {1'b0, base_reg, 52'd0} + mant_r;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        d_next      = d_reg;
        sticky_next = sticky_reg;
        sp_next     = sp_reg;
        sc_next     = sc_reg;
        cz_next     = cz_reg;
        sign_next   = sign_reg;
        base_next   = base_reg;
        pp_next     = pp_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (special)
                    begin
                        res_next  = special_res;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ma_next    = {ea != 11'd0, fa};
                        mb_next    = {eb != 11'd0, fb};
                        y_next     = {75'd0, ec != 11'd0, fc};
                        ex_next    = 16'(ea_eff) + 16'(eb_eff) - 16'd2150;
                        ey_next    = 16'(ec_eff) - 16'd1075;
                        x_next     = '0;
                        sp_next    = sp;
                        sc_next    = sc;
                        cz_next    = cz;
                        step_next  = 3'd0;
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                pp_next = mul_p;
                if (step_reg != 3'd0)
                    x_next = x_reg + x_add;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                    state_next = F_NORMP;
            end
            F_NORMP:
            begin
                if (x_reg[125])
                begin
                    if (cz_reg)
                    begin
                        sign_next  = sp_reg;
                        state_next = F_NORMR;
                    end
                    else
                    begin
                        state_next = F_NORMQ;
                    end
                end
                else if (x_reg[125:110] == 16'd0)
                begin
                    x_next  = x_reg << 16;
                    ex_next = ex_reg - 16'sd16;
                end
                else
                begin
                    x_next  = x_reg << 1;
                    ex_next = ex_reg - 16'sd1;
                end
            end
            F_NORMQ:
            begin
                if (y_reg[125])
                    state_next = F_CMP;
                else if (y_reg[125:110] == 16'd0)
                begin
                    y_next  = y_reg << 16;
                    ey_next = ey_reg - 16'sd16;
                end
                else
                begin
                    y_next  = y_reg << 1;
                    ey_next = ey_reg - 16'sd1;
                end
            end
            F_CMP:
            begin
                sticky_next = 1'b0;
                if (ex_reg > ey_reg || (ex_reg == ey_reg && x_reg >= y_reg))
                begin
                    d_next    = 16'(ex_reg - ey_reg);
                    sign_next = sp_reg;
                end
                else
                begin
                    x_next    = y_reg;
                    y_next    = x_reg;
                    ex_next   = ey_reg;
                    d_next    = 16'(ey_reg - ex_reg);
                    sign_next = sc_reg;
                end
                state_next = F_ALIGN;
            end
            F_ALIGN:
            begin
                y_next      = rs_y;
                d_next      = rs_d;
                sticky_next = rs_st;
                if (d_reg == 16'd0)
                    state_next = F_ADD;
            end
            F_ADD:
            begin
                x_next     = (sp_reg == sc_reg) ? x_reg + ys : x_reg - ys;
                state_next = F_NORMR;
            end
            F_NORMR:
            begin
                if (x_reg == 128'd0)
                begin
                    res_next   = 64'd0;
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else if (x_reg[126])
                    state_next = F_RSET;
                else if (x_reg[126:111] == 16'd0)
                begin
                    x_next  = x_reg << 16;
                    ex_next = ex_reg - 16'sd16;
                end
                else
                begin
                    x_next  = x_reg << 1;
                    ex_next = ex_reg - 16'sd1;
                end
            end
            F_RSET:
            begin
                y_next      = x_reg;
                sticky_next = 1'b0;
                if (exb > 16'sd2046)
                begin
                    res_next   = {sign_reg, FP_INF[62:0]};
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    if (exb >= 16'sd1)
                    begin
                        d_next    = 16'd73;
                        base_next = exb[10:0] - 11'd1;
                    end
                    else
                    begin
                        d_next    = 16'(16'sd74 - exb);
                        base_next = 11'd0;
                    end
                    state_next = F_RSHIFT;
                end
            end
            F_RSHIFT:
            begin
                y_next      = rs_y;
                d_next      = rs_d;
                sticky_next = rs_st;
                if (d_reg == 16'd0)
                    state_next = F_ROUND;
            end
            F_ROUND:
            begin
                res_next   = {sign_reg, (enc >= FP_INF) ? FP_INF[62:0] : enc[62:0]};
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        d_reg      <= d_next;
        sticky_reg <= sticky_next;
        sp_reg     <= sp_next;
        sc_reg     <= sc_next;
        cz_reg     <= cz_next;
        sign_reg   <= sign_next;
        base_reg   <= base_next;
        pp_reg     <= pp_next;
        res_reg    <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
